[hdl/smt_pkg.sv]
// Shared types and constants for the sorted multiset table.
`timescale 1ns / 1ps

package smt_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned FieldCntW   = 7;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_COUNT  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    req_type_e                req_type;
    logic signed [ValueW-1:0] value;
  } in_t;

  typedef struct packed {
    status_e                status;
    logic [FieldCntW-1:0]   occurrences;
    logic [FieldCntW-1:0]   entry_total;
  } out_t;

  typedef struct packed {
    logic                     valid;
    logic                     hit;
    logic signed [ValueW-1:0] carry;
  } tok_t;

endpackage

[hdl/smt_cell.sv]
// One cell of the table chain: holds one entry and forwards the request wave.
`timescale 1ns / 1ps

module smt_cell #(
  parameter int unsigned CAPACITY = smt_pkg::DefCapacity,
  parameter int unsigned IDX      = 0,
  localparam int unsigned CntW    = $clog2(CAPACITY + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  smt_pkg::in_t                     op_i,
  input  logic                             desc_i,
  input  logic [CntW-1:0]                  n_i,
  input  smt_pkg::tok_t                    tok_i,
  input  logic [CntW-1:0]                  occ_i,
  input  logic signed [smt_pkg::ValueW-1:0] nxt_entry_i,
  output smt_pkg::tok_t                    tok_o,
  output logic [CntW-1:0]                  occ_o,
  output logic signed [smt_pkg::ValueW-1:0] entry_o
);

  localparam logic [CntW-1:0] Idx  = CntW'(IDX);
  localparam logic [CntW-1:0] Full = CntW'(CAPACITY);

  logic signed [smt_pkg::ValueW-1:0] entry_q, entry_d;
  logic                              valid_q;
  logic                              hit_q, hit_d;
  logic signed [smt_pkg::ValueW-1:0] carry_q;
  logic [CntW-1:0]                   occ_q, occ_d;
  logic                              in_range, at_end, is_full, eq, after;

  always_comb begin
    in_range = (Idx < n_i);
    at_end   = (Idx == n_i);
    is_full  = (n_i == Full);
    eq       = (entry_q == op_i.value);
    after    = desc_i ? (entry_q < op_i.value) : (entry_q > op_i.value);
    entry_d  = entry_q;
    hit_d    = tok_i.hit;
    occ_d    = occ_i;
    if (tok_i.valid) begin
      case (op_i.req_type)
        smt_pkg::REQ_ADD: begin
          if (!is_full) begin
            if (tok_i.hit && (in_range || at_end)) begin
              entry_d = tok_i.carry;
            end else if (!tok_i.hit && ((in_range && after) || at_end)) begin
              hit_d   = 1'b1;
              entry_d = op_i.value;
            end
          end
        end
        smt_pkg::REQ_REMOVE: begin
          hit_d = tok_i.hit | (in_range & eq);
          if (hit_d && in_range) begin
            entry_d = nxt_entry_i;
          end
        end
        smt_pkg::REQ_SEARCH: begin
          hit_d = tok_i.hit | (in_range & eq);
        end
        smt_pkg::REQ_COUNT: begin
          occ_d = occ_i + CntW'(in_range & eq);
        end
        default: begin
          hit_d = tok_i.hit;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    hit_q   <= hit_d;
    carry_q <= entry_q;
    occ_q   <= occ_d;
  end

  assign tok_o.valid = valid_q;
  assign tok_o.hit   = hit_q;
  assign tok_o.carry = carry_q;
  assign occ_o       = occ_q;
  assign entry_o     = entry_q;

endmodule

[hdl/sorted_multiset_table_top.sv]
// Top level of the sorted multiset table: request control, cell chain and result register.
`timescale 1ns / 1ps

// Channel   Direction  Ports                          Transfer
// request   in         start, busy, req_i             start && !busy at rising edge
// result    out        res_valid_o, res_o             one cycle while res_valid_o is high
// config    in         cfg_we_i, cfg_wdata_i          cfg_we_i at rising edge
//
// A request sweeps the chain one cell per cycle; the result strobe rises at
// the same edge at which busy drops, so a new request is taken only once the
// previous result is out.
// Reset clears the entry count and the order mode; entries need no clearing.
// The receiver cannot stall: each result is shown for one cycle only.

module sorted_multiset_table_top #(
  parameter int unsigned CAPACITY = smt_pkg::DefCapacity,
  localparam int unsigned CntW    = $clog2(CAPACITY + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  smt_pkg::in_t  req_i,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  output logic          res_valid_o,
  output smt_pkg::out_t res_o
);

  localparam logic [CntW-1:0] Full = CntW'(CAPACITY);

  smt_pkg::in_t                      op_q;
  logic                              desc_q;
  logic                              busy_q;
  logic                              launch_q;
  logic [CntW-1:0]                   n_q, n_d;
  logic                              res_valid_q;
  smt_pkg::out_t                     res_q, res_d;
  logic                              accept;

  smt_pkg::tok_t                     tok   [CAPACITY+1];
  logic [CntW-1:0]                   occ   [CAPACITY+1];
  logic signed [smt_pkg::ValueW-1:0] entry [CAPACITY];
  logic [CAPACITY:0]                 wave_v;

  assign accept = start && !busy_q;

  assign tok[0].valid = launch_q;
  assign tok[0].hit   = 1'b0;
  assign tok[0].carry = '0;
  assign occ[0]       = '0;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [smt_pkg::ValueW-1:0] nxt;
    if (k == CAPACITY - 1) begin : g_last
      assign nxt = entry[k];
    end else begin : g_mid
      assign nxt = entry[k+1];
    end
    smt_cell #(
      .CAPACITY(CAPACITY),
      .IDX     (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .op_i       (op_q),
      .desc_i     (desc_q),
      .n_i        (n_q),
      .tok_i      (tok[k]),
      .occ_i      (occ[k]),
      .nxt_entry_i(nxt),
      .tok_o      (tok[k+1]),
      .occ_o      (occ[k+1]),
      .entry_o    (entry[k])
    );
  end

  for (genvar k = 0; k <= CAPACITY; k++) begin : g_wave
    assign wave_v[k] = tok[k].valid;
  end

  always_comb begin
    n_d               = n_q;
    res_d.status      = smt_pkg::ST_DONE;
    res_d.occurrences = '0;
    case (op_q.req_type)
      smt_pkg::REQ_ADD: begin
        if (n_q == Full) begin
          res_d.status = smt_pkg::ST_FULL;
        end else begin
          n_d = n_q + CntW'(1);
        end
      end
      smt_pkg::REQ_REMOVE: begin
        if (tok[CAPACITY].hit) begin
          n_d = n_q - CntW'(1);
        end else begin
          res_d.status = smt_pkg::ST_NOT_FOUND;
        end
      end
      smt_pkg::REQ_SEARCH: begin
        if (!tok[CAPACITY].hit) begin
          res_d.status = smt_pkg::ST_NOT_FOUND;
        end
      end
      smt_pkg::REQ_COUNT: begin
        res_d.occurrences = smt_pkg::FieldCntW'(occ[CAPACITY]);
      end
      default: begin
        res_d.status = smt_pkg::ST_DONE;
      end
    endcase
    res_d.entry_total = smt_pkg::FieldCntW'(n_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q      <= 1'b0;
      busy_q      <= 1'b0;
      launch_q    <= 1'b0;
      n_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        desc_q <= cfg_wdata_i;
      end
      launch_q    <= accept;
      res_valid_q <= tok[CAPACITY].valid;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (tok[CAPACITY].valid) begin
        busy_q <= 1'b0;
      end
      if (tok[CAPACITY].valid) begin
        n_q <= n_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= req_i;
    end
    if (tok[CAPACITY].valid) begin
      res_q <= res_d;
    end
  end

  assign busy        = busy_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_busy_after_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("busy not raised after request transfer");

  a_single_wave : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(wave_v))
    else $error("more than one request wave in the chain");

  a_result_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> !busy_q && $past(wave_v[CAPACITY]))
    else $error("result strobe without finished sweep");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= Full)
    else $error("entry count beyond capacity");

  a_full_total : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && (res_q.status == smt_pkg::ST_FULL) |-> (n_q == Full))
    else $error("full status with free entries");

endmodule

[verif/tb_sorted_multiset_table_top.sv]
// Testbench for sorted_multiset_table_top: scoreboard class, directed and random requests.
`timescale 1ns / 1ps

module tb_sorted_multiset_table_top;

  localparam int unsigned Capacity    = smt_pkg::DefCapacity;
  localparam int unsigned ValueW      = smt_pkg::ValueW;
  localparam int unsigned FieldCntW   = smt_pkg::FieldCntW;
  localparam int unsigned IdlePct     = 26;
  localparam int unsigned StallLimit  = 4 * (Capacity + 2) + 1000;
  localparam int unsigned DrainCycles = Capacity + 8;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned PhaseItems  = 160;
  localparam int unsigned PoolSize    = 6;
  localparam int unsigned MaxPrinted  = 100;

  localparam logic signed [ValueW-1:0] MinValue = 32'sh8000_0000;
  localparam logic signed [ValueW-1:0] MaxValue = 32'sh7fff_ffff;

  typedef struct packed {
    smt_pkg::in_t  req;
    smt_pkg::out_t res;
  } req_result_t;

  class sorted_bag_scoreboard;
    logic signed [ValueW-1:0] entries [Capacity];
    int unsigned entry_count;
    bit          descending;
    req_result_t awaited_results [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned refused;
    int unsigned misses;

    function new();
      entry_count = 0;
      descending  = 1'b0;
      errors      = 0;
      checked     = 0;
      refused     = 0;
      misses      = 0;
    endfunction

    task report(string msg);
      if (errors < MaxPrinted) $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    function logic signed [ValueW-1:0] sample_stored();
      return entries[$urandom_range(entry_count - 1)];
    endfunction

    function void note_request(smt_pkg::in_t req);
      req_result_t              item;
      logic signed [ValueW-1:0] v;
      int unsigned              pos;
      int unsigned              occ;
      bit                       after;
      v                    = req.value;
      item.req             = req;
      item.res.status      = smt_pkg::ST_DONE;
      occ                  = 0;
      pos                  = entry_count;
      case (req.req_type)
        smt_pkg::REQ_ADD: begin
          if (entry_count >= Capacity) begin
            item.res.status = smt_pkg::ST_FULL;
          end else begin
            for (int i = 0; i < entry_count; i++) begin
              after = descending ? (entries[i] < v) : (entries[i] > v);
              if (after) begin
                pos = i;
                break;
              end
            end
            for (int i = entry_count; i > pos; i--) entries[i] = entries[i-1];
            entries[pos] = v;
            entry_count++;
          end
        end
        smt_pkg::REQ_REMOVE: begin
          for (int i = 0; i < entry_count; i++) begin
            if (entries[i] == v) begin
              pos = i;
              break;
            end
          end
          if (pos == entry_count) begin
            item.res.status = smt_pkg::ST_NOT_FOUND;
          end else begin
            for (int i = pos; i + 1 < entry_count; i++) entries[i] = entries[i+1];
            entry_count--;
          end
        end
        smt_pkg::REQ_SEARCH: begin
          item.res.status = smt_pkg::ST_NOT_FOUND;
          for (int i = 0; i < entry_count; i++) begin
            if (entries[i] == v) item.res.status = smt_pkg::ST_DONE;
          end
        end
        default: begin
          for (int i = 0; i < entry_count; i++) begin
            if (entries[i] == v) occ++;
          end
        end
      endcase
      item.res.occurrences = FieldCntW'(occ);
      item.res.entry_total = FieldCntW'(entry_count);
      awaited_results.push_back(item);
    endfunction

    task check_result(smt_pkg::out_t got);
      req_result_t want;
      if (awaited_results.size() == 0) begin
        report($sformatf("result %p with no request pending", got));
      end else begin
        want = awaited_results.pop_front();
        checked++;
        if (want.res.status == smt_pkg::ST_FULL) refused++;
        if (want.res.status == smt_pkg::ST_NOT_FOUND) misses++;
        if (got.status !== want.res.status)
          report($sformatf("%s %0d: status got %0d want %0d", want.req.req_type.name(),
                           want.req.value, got.status, want.res.status));
        if (got.occurrences !== want.res.occurrences)
          report($sformatf("%s %0d: occurrences got %0d want %0d",
                           want.req.req_type.name(), want.req.value,
                           got.occurrences, want.res.occurrences));
        if (got.entry_total !== want.res.entry_total)
          report($sformatf("%s %0d: entry_total got %0d want %0d",
                           want.req.req_type.name(), want.req.value,
                           got.entry_total, want.res.entry_total));
      end
    endtask
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          start;
  logic          busy;
  smt_pkg::in_t  req_i;
  logic          cfg_we_i;
  logic          cfg_wdata_i;
  logic          res_valid_o;
  smt_pkg::out_t res_o;

  sorted_bag_scoreboard scoreboard = new();
  int unsigned          sent_count  = 0;
  int unsigned          order_writes = 0;
  int unsigned          quiet_cycles = 0;

  sorted_multiset_table_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) scoreboard.check_result(res_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni && ((start && !busy) || res_valid_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("sorted_multiset_table_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic idle_cycle();
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task automatic send_request(smt_pkg::req_type_e kind, logic signed [ValueW-1:0] val);
    smt_pkg::in_t item;
    item.req_type = kind;
    item.value    = val;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= item;
    do @(posedge clk_i); while (busy !== 1'b0);
    scoreboard.note_request(req_i);
    sent_count++;
  endtask

  task automatic write_order(bit desc);
    idle_cycle();
    while (scoreboard.awaited_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    start       <= 1'b0;
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= desc;
    @(posedge clk_i);
    scoreboard.descending = desc;
    order_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic signed [ValueW-1:0] pool [PoolSize];
    logic signed [ValueW-1:0] val;
    smt_pkg::req_type_e       kind;
    int unsigned              r;
    bit                       fill;
    bit                       quiet;
    start       = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    rst_ni      = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty store, extremes and duplicates, ascending after reset
    send_request(smt_pkg::REQ_SEARCH, 32'sd5);
    send_request(smt_pkg::REQ_COUNT,  32'sd5);
    send_request(smt_pkg::REQ_REMOVE, 32'sd5);
    send_request(smt_pkg::REQ_ADD,    32'sd0);
    send_request(smt_pkg::REQ_ADD,    MaxValue);
    send_request(smt_pkg::REQ_ADD,    MinValue);
    send_request(smt_pkg::REQ_ADD,    -32'sd1);
    send_request(smt_pkg::REQ_ADD,    32'sd0);
    send_request(smt_pkg::REQ_ADD,    MaxValue);
    send_request(smt_pkg::REQ_COUNT,  32'sd0);
    send_request(smt_pkg::REQ_SEARCH, MinValue);
    send_request(smt_pkg::REQ_SEARCH, 32'sd1);
    send_request(smt_pkg::REQ_REMOVE, 32'sd0);
    send_request(smt_pkg::REQ_COUNT,  32'sd0);
    send_request(smt_pkg::REQ_REMOVE, 32'sd12345);
    // flip the order with entries held
    write_order(1'b1);
    send_request(smt_pkg::REQ_ADD,    32'sd3);
    send_request(smt_pkg::REQ_ADD,    32'sd0);
    send_request(smt_pkg::REQ_ADD,    MinValue);
    send_request(smt_pkg::REQ_COUNT,  MinValue);
    send_request(smt_pkg::REQ_REMOVE, MaxValue);
    send_request(smt_pkg::REQ_SEARCH, MaxValue);
    send_request(smt_pkg::REQ_COUNT,  MaxValue);

    for (int p = 0; p < NumPhases; p++) begin
      write_order((p < 4) ? p[0] : 1'($urandom_range(1)));
      fill  = (p[1] == 1'b0);
      quiet = (p == 3);
      for (int k = 0; k < PoolSize; k++) begin
        pool[k] = (k < 3) ? ValueW'($urandom_range(8)) - 32'sd4 : $urandom;
      end
      for (int n = 0; n < PhaseItems; n++) begin
        if (!quiet) begin
          while ($urandom_range(99) < IdlePct) idle_cycle();
          if ($urandom_range(19) == 0) repeat ($urandom_range(1, Capacity + 4)) idle_cycle();
        end
        r = $urandom_range(99);
        if (fill) begin
          kind = (r < 65) ? smt_pkg::REQ_ADD : (r < 75) ? smt_pkg::REQ_REMOVE :
                 (r < 88) ? smt_pkg::REQ_SEARCH : smt_pkg::REQ_COUNT;
        end else begin
          kind = (r < 15) ? smt_pkg::REQ_ADD : (r < 65) ? smt_pkg::REQ_REMOVE :
                 (r < 82) ? smt_pkg::REQ_SEARCH : smt_pkg::REQ_COUNT;
        end
        r = $urandom_range(99);
        if (kind != smt_pkg::REQ_ADD && scoreboard.entry_count > 0 && r < 50) begin
          val = scoreboard.sample_stored();
        end else if (r < 75) begin
          val = pool[$urandom_range(PoolSize - 1)];
        end else if (r < 85) begin
          case ($urandom_range(3))
            0:       val = MinValue;
            1:       val = MaxValue;
            2:       val = 32'sd0;
            default: val = -32'sd1;
          endcase
        end else begin
          val = $urandom;
        end
        send_request(kind, val);
      end
    end

    idle_cycle();
    while (scoreboard.awaited_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (scoreboard.awaited_results.size() != 0)
      scoreboard.report("results still pending at end of run");

    $display("Sent %0d requests, checked %0d results: %0d refused as full, %0d not found",
             sent_count, scoreboard.checked, scoreboard.refused, scoreboard.misses);
    $display("Order mode written %0d times across both directions, %0d mismatches",
             order_writes, scoreboard.errors);
    if (scoreboard.errors == 0) begin
      $display("sorted_multiset_table_top verification clean");
    end else begin
      $display("sorted_multiset_table_top verification failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/smt_pkg.sv
hdl/smt_cell.sv
hdl/sorted_multiset_table_top.sv
verif/tb_sorted_multiset_table_top.sv
